// ===== src/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types and constants for the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

    localparam int unsigned IDX_W       = 6;   // row / col field width
    localparam int unsigned ELEM_W      = 16;  // Q8.8 element
    localparam int unsigned PROD_W      = 32;  // Q16.16 product
    localparam int unsigned ACC_W       = 40;  // Q24.16 accumulated sum
    localparam int unsigned SIZE_W      = 7;   // size register width
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CMP_W       = 9;   // holds values up to 511
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = QPTR_W + 1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    typedef enum logic [1:0] {
        FN_WR_A = 2'd0,
        FN_WR_B = 2'd1,
        FN_READ = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_M  = 2'd0,
        REG_INNER_K = 2'd1,
        REG_COLS_N  = 2'd2
    } cfg_reg_t;

    // classified command held in the queue
    typedef enum logic [1:0] {
        OP_WR_A  = 2'd0,
        OP_WR_B  = 2'd1,
        OP_READ  = 2'd2,
        OP_RANGE = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [ELEM_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [SIZE_W-1:0] rows_m;
        logic [SIZE_W-1:0] inner_k;
        logic [SIZE_W-1:0] cols_n;
    } sizes_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_ISSUE = 2'd1,
        BK_DRAIN = 2'd2
    } bk_state_t;

endpackage

// ===== src/mme_ram.sv =====
// ----------------------------------------------------------------------------
// mme_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mme_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/mme_front.sv =====
// ----------------------------------------------------------------------------
// mme_front
// Accepts commands, range-checks them and queues them for the back end.
// ----------------------------------------------------------------------------
module mme_front #(
    parameter int unsigned MAX_DIM = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   func,
    input  logic [mme_pkg::IDX_W-1:0]    row,
    input  logic [mme_pkg::IDX_W-1:0]    col,
    input  logic [mme_pkg::ELEM_W-1:0]   value,
    input  mme_pkg::sizes_t              sizes,
    input  logic                         pop,
    output logic                         q_valid,
    output mme_pkg::cmd_t                q_head
);

    localparam logic [mme_pkg::CMP_W-1:0] MAX_C = mme_pkg::CMP_W'(MAX_DIM);

    mme_pkg::cmd_t                 q_mem_reg [mme_pkg::QUEUE_DEPTH];
    logic [mme_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mme_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mme_pkg::QCNT_W-1:0]    count_reg, count_next;

    logic [mme_pkg::CMP_W-1:0] row_c, col_c;
    logic                      row_in_m, row_in_k, col_in_k, col_in_n;
    logic                      keep;
    logic                      push;
    mme_pkg::cmd_t             cmd;

    assign busy    = (count_reg == mme_pkg::QCNT_W'(mme_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_head  = q_mem_reg[rd_ptr_reg];

    // sizes above MAX_DIM act as MAX_DIM
    assign row_c    = mme_pkg::CMP_W'(row);
    assign col_c    = mme_pkg::CMP_W'(col);
    assign row_in_m = (row_c < mme_pkg::CMP_W'(sizes.rows_m))  && (row_c < MAX_C);
    assign row_in_k = (row_c < mme_pkg::CMP_W'(sizes.inner_k)) && (row_c < MAX_C);
    assign col_in_k = (col_c < mme_pkg::CMP_W'(sizes.inner_k)) && (col_c < MAX_C);
    assign col_in_n = (col_c < mme_pkg::CMP_W'(sizes.cols_n))  && (col_c < MAX_C);

    always_comb
    begin
        cmd.row   = row;
        cmd.col   = col;
        cmd.value = value;
        cmd.op    = mme_pkg::OP_RANGE;
        keep      = 1'b0;
        unique case (mme_pkg::func_t'(func))
            mme_pkg::FN_WR_A:
            begin
                cmd.op = mme_pkg::OP_WR_A;
                keep   = row_in_m && col_in_k;
            end
            mme_pkg::FN_WR_B:
            begin
                cmd.op = mme_pkg::OP_WR_B;
                keep   = row_in_k && col_in_n;
            end
            mme_pkg::FN_READ:
            begin
                cmd.op = (row_in_m && col_in_n) ? mme_pkg::OP_READ : mme_pkg::OP_RANGE;
                keep   = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = start && !busy && keep;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + mme_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + mme_pkg::QPTR_W'(1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + mme_pkg::QCNT_W'(1);
            2'b01:   count_next = count_reg - mme_pkg::QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mme_pkg::QCNT_W'(mme_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

endmodule

// ===== src/mme_back.sv =====
// ----------------------------------------------------------------------------
// mme_back
// Executes queued commands: element writes and dot-product reads, one MAC
// per cycle through the two element stores.
// ----------------------------------------------------------------------------
module mme_back #(
    parameter int unsigned MAX_DIM = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mme_pkg::sizes_t                       sizes,
    input  logic                                  q_valid,
    input  mme_pkg::cmd_t                         q_head,
    output logic                                  pop,
    output logic                                  a_we,
    output logic                                  b_we,
    output logic [((MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] waddr,
    output logic [mme_pkg::ELEM_W-1:0]            wdata,
    output logic [((MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] a_raddr,
    output logic [((MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] b_raddr,
    input  logic [mme_pkg::ELEM_W-1:0]            a_rdata,
    input  logic [mme_pkg::ELEM_W-1:0]            b_rdata,
    output logic                                  done,
    output logic [mme_pkg::ACC_W-1:0]             product_value,
    output logic                                  range_error
);

    localparam int unsigned AW = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int unsigned CW = $clog2(MAX_DIM + 1);
    localparam logic [mme_pkg::CMP_W-1:0] MAX_C = mme_pkg::CMP_W'(MAX_DIM);

    mme_pkg::bk_state_t state_reg, state_next;

    logic [CW-1:0]                     t_reg, t_next;
    logic [AW-1:0]                     a_raddr_reg, a_raddr_next;
    logic [AW-1:0]                     b_raddr_reg, b_raddr_next;
    logic                              rd_vld_reg, rd_last_reg;
    logic signed [mme_pkg::PROD_W-1:0] prod_reg;
    logic                              prod_vld_reg, prod_last_reg;
    logic signed [mme_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic                              done_reg, done_next;
    logic [mme_pkg::ACC_W-1:0]         pv_reg, pv_next;
    logic                              err_reg, err_next;

    logic [mme_pkg::CMP_W-1:0]         k_eff;
    logic                              last_issue;
    logic                              issue;
    logic [AW-1:0]                     row_base;
    logic signed [mme_pkg::ACC_W-1:0]  acc_sum;

    assign k_eff = (mme_pkg::CMP_W'(sizes.inner_k) > MAX_C) ? MAX_C
                                                            : mme_pkg::CMP_W'(sizes.inner_k);
    assign last_issue = (mme_pkg::CMP_W'(t_reg) + mme_pkg::CMP_W'(1)) == k_eff;

    // entry (r,c) sits at r*MAX_DIM + c
    assign row_base = AW'(q_head.row) * AW'(MAX_DIM);
    assign waddr    = row_base + AW'(q_head.col);
    assign wdata    = q_head.value;
    assign a_raddr  = a_raddr_reg;
    assign b_raddr  = b_raddr_reg;

    assign acc_sum = acc_reg + mme_pkg::ACC_W'(prod_reg);

    always_comb
    begin
        state_next   = state_reg;
        t_next       = t_reg;
        a_raddr_next = a_raddr_reg;
        b_raddr_next = b_raddr_reg;
        acc_next     = prod_vld_reg ? acc_sum : acc_reg;
        done_next    = 1'b0;
        pv_next      = pv_reg;
        err_next     = err_reg;
        pop          = 1'b0;
        a_we         = 1'b0;
        b_we         = 1'b0;
        issue        = 1'b0;
        unique case (state_reg)
            mme_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    unique case (q_head.op)
                        mme_pkg::OP_WR_A:
                        begin
                            a_we = 1'b1;
                        end
                        mme_pkg::OP_WR_B:
                        begin
                            b_we = 1'b1;
                        end
                        mme_pkg::OP_RANGE:
                        begin
                            done_next = 1'b1;
                            pv_next   = '0;
                            err_next  = 1'b1;
                        end
                        mme_pkg::OP_READ:
                        begin
                            if (k_eff == '0)
                            begin
                                done_next = 1'b1;
                                pv_next   = '0;
                                err_next  = 1'b0;
                            end
                            else
                            begin
                                state_next   = mme_pkg::BK_ISSUE;
                                t_next       = '0;
                                a_raddr_next = row_base;
                                b_raddr_next = AW'(q_head.col);
                                acc_next     = '0;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            mme_pkg::BK_ISSUE:
            begin
                issue        = 1'b1;
                t_next       = t_reg + CW'(1);
                a_raddr_next = a_raddr_reg + AW'(1);
                b_raddr_next = b_raddr_reg + AW'(MAX_DIM);
                if (last_issue)
                begin
                    state_next = mme_pkg::BK_DRAIN;
                end
            end
            mme_pkg::BK_DRAIN:
            begin
                if (prod_vld_reg && prod_last_reg)
                begin
                    done_next  = 1'b1;
                    pv_next    = acc_sum;
                    err_next   = 1'b0;
                    state_next = mme_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = mme_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mme_pkg::BK_IDLE;
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
            done_reg      <= 1'b0;
            err_reg       <= 1'b0;
            pv_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= issue;
            rd_last_reg   <= issue && last_issue;
            prod_vld_reg  <= rd_vld_reg;
            prod_last_reg <= rd_last_reg;
            done_reg      <= done_next;
            err_reg       <= err_next;
            pv_reg        <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg       <= t_next;
        a_raddr_reg <= a_raddr_next;
        b_raddr_reg <= b_raddr_next;
        acc_reg     <= acc_next;
        prod_reg    <= signed'(a_rdata) * signed'(b_rdata);
    end

    assign done          = done_reg;
    assign product_value = pv_reg;
    assign range_error   = err_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == mme_pkg::BK_IDLE)
        else $error("result beat while a read is still in flight");

    a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mme_pkg::BK_IDLE) |-> !rd_vld_reg && !prod_vld_reg)
        else $error("MAC pipeline busy in idle");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> pv_reg == '0)
        else $error("flagged read with nonzero value");

endmodule

// ===== src/matrix_multiply_engine.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// C = A x B over Q8.8 elements with an exact 40-bit Q24.16 dot product.
// ----------------------------------------------------------------------------
// An element write is done as it leaves the queue; a flagged read (index
// outside the sizes) or a read with inner_k at 0 is answered from idle.
// An in-range read walks the k entries of the inner dimension through the
// two element RAMs at one multiply-accumulate per cycle (k being inner_k
// capped at MAX_DIM), holding the back end through its issue and drain
// states, then pulses done. A two-entry command queue sits in front, so
// start is taken while a read is running until the queue is full (busy
// high). Results come out in command order as one-cycle beats on done and
// cannot be held off. Config writes are meant for idle periods only.
// ----------------------------------------------------------------------------
module matrix_multiply_engine #(
    parameter int unsigned MAX_DIM = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mme_pkg::SIZE_W-1:0]       cfg_data,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       func,
    input  logic [mme_pkg::IDX_W-1:0]        row,
    input  logic [mme_pkg::IDX_W-1:0]        col,
    input  logic signed [mme_pkg::ELEM_W-1:0] value,
    output logic                             done,
    output logic signed [mme_pkg::ACC_W-1:0] product_value,
    output logic                             range_error
);

    localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mme_pkg::sizes_t sizes_reg, sizes_next;

    logic                         q_valid;
    mme_pkg::cmd_t                q_head;
    logic                         pop;
    logic                         a_we, b_we;
    logic [AW-1:0]                waddr, a_raddr, b_raddr;
    logic [mme_pkg::ELEM_W-1:0]   wdata, a_rdata, b_rdata;
    logic [mme_pkg::ACC_W-1:0]    pv;

    always_comb
    begin
        sizes_next = sizes_reg;
        if (cfg_we)
        begin
            unique case (mme_pkg::cfg_reg_t'(cfg_index))
                mme_pkg::REG_ROWS_M:  sizes_next.rows_m  = cfg_data;
                mme_pkg::REG_INNER_K: sizes_next.inner_k = cfg_data;
                mme_pkg::REG_COLS_N:  sizes_next.cols_n  = cfg_data;
                default:              sizes_next = sizes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sizes_reg.rows_m  <= mme_pkg::SIZE_RESET;
            sizes_reg.inner_k <= mme_pkg::SIZE_RESET;
            sizes_reg.cols_n  <= mme_pkg::SIZE_RESET;
        end
        else
        begin
            sizes_reg <= sizes_next;
        end
    end

    mme_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .func    (func),
        .row     (row),
        .col     (col),
        .value   (value),
        .sizes   (sizes_reg),
        .pop     (pop),
        .q_valid (q_valid),
        .q_head  (q_head)
    );

    mme_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .sizes         (sizes_reg),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .pop           (pop),
        .a_we          (a_we),
        .b_we          (b_we),
        .waddr         (waddr),
        .wdata         (wdata),
        .a_raddr       (a_raddr),
        .b_raddr       (b_raddr),
        .a_rdata       (a_rdata),
        .b_rdata       (b_rdata),
        .done          (done),
        .product_value (pv),
        .range_error   (range_error)
    );

    mme_ram #(
        .WIDTH (mme_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mme_ram #(
        .WIDTH (mme_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_b_store (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    assign product_value = signed'(pv);

endmodule

// ===== test/mme_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mme_checker
// Watches the command, config and result ports of the matrix multiply engine.
// It keeps its own copy of the A and B element stores and of the size
// registers, and works out C[row][col] for every accepted read. Each result
// beat is then checked against the oldest expected value.
// ----------------------------------------------------------------------------
module mme_checker #(
    parameter int unsigned MAX_DIM = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mme_pkg::SIZE_W-1:0]        cfg_data,
    input  logic                              start,
    input  logic                              busy,
    input  logic [1:0]                        func,
    input  logic [mme_pkg::IDX_W-1:0]         row,
    input  logic [mme_pkg::IDX_W-1:0]         col,
    input  logic signed [mme_pkg::ELEM_W-1:0] value,
    input  logic                              done,
    input  logic signed [mme_pkg::ACC_W-1:0]  product_value,
    input  logic                              range_error,
    output int                                mismatches,
    output int                                pending
);

    typedef struct packed {
        logic signed [mme_pkg::ACC_W-1:0] sum;
        logic                             flagged;
    } c_elem_t;

    c_elem_t                           c_awaited [$];
    logic signed [mme_pkg::ELEM_W-1:0] a_mem [MAX_DIM*MAX_DIM];
    logic signed [mme_pkg::ELEM_W-1:0] b_mem [MAX_DIM*MAX_DIM];
    logic [mme_pkg::SIZE_W-1:0]        size_m = mme_pkg::SIZE_RESET;
    logic [mme_pkg::SIZE_W-1:0]        size_k = mme_pkg::SIZE_RESET;
    logic [mme_pkg::SIZE_W-1:0]        size_n = mme_pkg::SIZE_RESET;

    // sizes above MAX_DIM act as MAX_DIM
    function automatic int unsigned capped(logic [mme_pkg::SIZE_W-1:0] r);
        return (r > MAX_DIM) ? MAX_DIM : int'(r);
    endfunction

    function automatic c_elem_t dot_product(int unsigned i, int unsigned j);
        c_elem_t     res;
        longint      acc;
        int unsigned k;
        acc = 0;
        k = capped(size_k);
        res.flagged = (i >= capped(size_m)) || (j >= capped(size_n));
        if (!res.flagged)
            for (int unsigned t = 0; t < k; t++)
                acc += longint'(a_mem[i*MAX_DIM + t]) * longint'(b_mem[t*MAX_DIM + j]);
        res.sum = acc[mme_pkg::ACC_W-1:0];
        return res;
    endfunction

    always @(posedge clk) begin
        c_elem_t     want;
        int unsigned m, k, n;
        if (rst_n) begin
            // result beats first: a command taken at this edge cannot answer here
            if (done) begin
                if (c_awaited.size() == 0) begin
                    $error("result beat with nothing awaited: product_value=%0d range_error=%0b",
                           product_value, range_error);
                    mismatches++;
                end else begin
                    want = c_awaited.pop_front();
                    if (product_value !== want.sum) begin
                        $error("product_value: expected %0d, got %0d", want.sum, product_value);
                        mismatches++;
                    end
                    if (range_error !== want.flagged) begin
                        $error("range_error: expected %0b, got %0b", want.flagged, range_error);
                        mismatches++;
                    end
                end
            end

            if (cfg_we) begin
                case (cfg_index)
                    mme_pkg::REG_ROWS_M:  size_m = cfg_data;
                    mme_pkg::REG_INNER_K: size_k = cfg_data;
                    mme_pkg::REG_COLS_N:  size_n = cfg_data;
                    default: ;
                endcase
            end

            if (start && !busy) begin
                m = capped(size_m);
                k = capped(size_k);
                n = capped(size_n);
                case (func)
                    mme_pkg::FN_WR_A:
                        if (row < m && col < k) a_mem[row*MAX_DIM + col] = value;
                    mme_pkg::FN_WR_B:
                        if (row < k && col < n) b_mem[row*MAX_DIM + col] = value;
                    mme_pkg::FN_READ: c_awaited.push_back(dot_product(row, col));
                    default: ;
                endcase
            end
            pending = c_awaited.size();
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the matrix multiply engine.
// Runs a short directed set, then random phases over a range of matrix
// sizes (zero, one, full and beyond the store size). Reads are mostly
// preceded by the element writes they depend on, so no read ever touches
// an entry that was never loaded. Checking is done in mme_checker.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned MAX_DIM     = 64;
    localparam logic [1:0]  FN_SPARE    = 2'd3;          // unused code, no effect
    localparam int unsigned SETTLE      = MAX_DIM + 16;  // back end drain after last beat
    localparam int unsigned CYCLE_LIMIT = 1500000;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [mme_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [mme_pkg::SIZE_W-1:0]        cfg_data = '0;
    logic                              start = 1'b0;
    logic                              busy;
    logic [1:0]                        func = '0;
    logic [mme_pkg::IDX_W-1:0]         row = '0;
    logic [mme_pkg::IDX_W-1:0]         col = '0;
    logic signed [mme_pkg::ELEM_W-1:0] value = '0;
    logic                              done;
    logic signed [mme_pkg::ACC_W-1:0]  product_value;
    logic                              range_error;
    int                                mismatches;
    int                                pending;

    // stimulus-side view of sizes and of which store entries hold data
    logic [mme_pkg::SIZE_W-1:0] size_m = mme_pkg::SIZE_RESET;
    logic [mme_pkg::SIZE_W-1:0] size_k = mme_pkg::SIZE_RESET;
    logic [mme_pkg::SIZE_W-1:0] size_n = mme_pkg::SIZE_RESET;
    bit                         a_loaded [MAX_DIM*MAX_DIM];
    bit                         b_loaded [MAX_DIM*MAX_DIM];
    int                         burst_left = 0;
    bit                         steady = 1'b0;
    int                         accepted = 0;

    matrix_multiply_engine #(.MAX_DIM(MAX_DIM)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .func(func), .row(row), .col(col), .value(value),
        .done(done), .product_value(product_value), .range_error(range_error)
    );

    mme_checker #(.MAX_DIM(MAX_DIM)) watch (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .func(func), .row(row), .col(col), .value(value),
        .done(done), .product_value(product_value), .range_error(range_error),
        .mismatches(mismatches), .pending(pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb NOT OK");
        $finish;
    end

    function automatic int unsigned capped(logic [mme_pkg::SIZE_W-1:0] r);
        return (r > MAX_DIM) ? MAX_DIM : int'(r);
    endfunction

    function automatic logic signed [mme_pkg::ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return -16'sh0001;
            default: return mme_pkg::ELEM_W'($urandom);
        endcase
    endfunction

    // random bursts; a gap long enough to cover a full-length read now and then
    task automatic pace();
        int gap;
        if (!steady) begin
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 16);
                gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 80)
                                                  : $urandom_range(1, 6);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic issue(input logic [1:0] f, input int unsigned r, input int unsigned c,
                         input logic signed [mme_pkg::ELEM_W-1:0] v);
        int unsigned m, k, n;
        bit          live;
        start <= 1'b1;
        func  <= f;
        row   <= mme_pkg::IDX_W'(r);
        col   <= mme_pkg::IDX_W'(c);
        value <= v;
        do @(posedge clk); while (busy);
        m = capped(size_m);
        k = capped(size_k);
        n = capped(size_n);
        live = 1'b0;
        case (f)
            mme_pkg::FN_WR_A:
                if (r < m && c < k) begin a_loaded[r*MAX_DIM + c] = 1'b1; live = 1'b1; end
            mme_pkg::FN_WR_B:
                if (r < k && c < n) begin b_loaded[r*MAX_DIM + c] = 1'b1; live = 1'b1; end
            mme_pkg::FN_READ: live = 1'b1;
            default: ;
        endcase
        if (live) accepted++;
        pace();
    endtask

    // wait for every result beat, then let trailing writes drain
    task automatic settle();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(input logic [mme_pkg::SIZE_W-1:0] m,
                             input logic [mme_pkg::SIZE_W-1:0] k,
                             input logic [mme_pkg::SIZE_W-1:0] n);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= mme_pkg::REG_ROWS_M;
        cfg_data  <= m;
        @(posedge clk);
        cfg_index <= mme_pkg::REG_INNER_K;
        cfg_data  <= k;
        @(posedge clk);
        cfg_index <= mme_pkg::REG_COLS_N;
        cfg_data  <= n;
        @(posedge clk);
        cfg_we <= 1'b0;
        size_m = m;
        size_k = k;
        size_n = n;
    endtask

    // in-range read: load any missing A row / B column entries first
    task automatic read_at(input int unsigned i, input int unsigned j);
        int unsigned k;
        k = capped(size_k);
        if (i < capped(size_m) && j < capped(size_n)) begin
            for (int unsigned t = 0; t < k; t++) begin
                if (!a_loaded[i*MAX_DIM + t]) issue(mme_pkg::FN_WR_A, i, t, rand_elem());
                if (!b_loaded[t*MAX_DIM + j]) issue(mme_pkg::FN_WR_B, t, j, rand_elem());
            end
        end
        issue(mme_pkg::FN_READ, i, j, mme_pkg::ELEM_W'($urandom));
    endtask

    task automatic random_item();
        int unsigned m, k, n;
        int          pick;
        m = capped(size_m);
        k = capped(size_k);
        n = capped(size_n);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            if (m > 0 && n > 0)
                read_at($urandom_range(0, m-1), $urandom_range(0, n-1));
            else
                read_at($urandom_range(0, 63), $urandom_range(0, 63));
        end else if (pick < 65) begin
            if (m > 0 && k > 0)
                issue(mme_pkg::FN_WR_A, $urandom_range(0, m-1), $urandom_range(0, k-1),
                      rand_elem());
            else
                issue(mme_pkg::FN_WR_A, $urandom_range(0, 63), $urandom_range(0, 63),
                      rand_elem());
        end else if (pick < 80) begin
            if (k > 0 && n > 0)
                issue(mme_pkg::FN_WR_B, $urandom_range(0, k-1), $urandom_range(0, n-1),
                      rand_elem());
            else
                issue(mme_pkg::FN_WR_B, $urandom_range(0, 63), $urandom_range(0, 63),
                      rand_elem());
        end else if (pick < 88) begin
            issue($urandom_range(0, 1) ? mme_pkg::FN_WR_B : mme_pkg::FN_WR_A,
                  $urandom_range(0, 63), $urandom_range(0, 63), rand_elem());
        end else if (pick < 96) begin
            read_at($urandom_range(0, 63), $urandom_range(0, 63));
        end else begin
            issue(FN_SPARE, $urandom_range(0, 63), $urandom_range(0, 63),
                  mme_pkg::ELEM_W'($urandom));
        end
    endtask

    task automatic run_phase(input logic [mme_pkg::SIZE_W-1:0] m,
                             input logic [mme_pkg::SIZE_W-1:0] k,
                             input logic [mme_pkg::SIZE_W-1:0] n, input int budget);
        int target;
        configure(m, k, n);
        steady = ($urandom_range(0, 3) == 0);
        burst_left = 0;
        target = accepted + budget;
        while (accepted < target) random_item();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme products, ignored writes, spare code, flagged reads
        configure(7'd2, 7'd3, 7'd2);
        for (int unsigned t = 0; t < 3; t++) begin
            issue(mme_pkg::FN_WR_A, 0, t, 16'sh8000);
            issue(mme_pkg::FN_WR_B, t, 0, 16'sh8000);
        end
        issue(mme_pkg::FN_READ, 0, 0, 16'sh0000);
        for (int unsigned t = 0; t < 3; t++) issue(mme_pkg::FN_WR_A, 1, t, 16'sh7FFF);
        issue(mme_pkg::FN_READ, 1, 0, -16'sh0001);
        issue(mme_pkg::FN_WR_A, 2, 0, 16'sh1234);   // row past rows_m
        issue(mme_pkg::FN_WR_B, 0, 2, 16'sh4321);   // col past cols_n
        issue(mme_pkg::FN_WR_A, 0, 3, 16'sh5A5A);   // col past inner_k
        issue(FN_SPARE, 63, 63, -16'sh0001);
        issue(mme_pkg::FN_READ, 2, 0, 16'sh0000);
        issue(mme_pkg::FN_READ, 0, 2, 16'sh0000);
        issue(mme_pkg::FN_READ, 63, 63, 16'sh7FFF);
        read_at(1, 1);

        run_phase(7'd1,   7'd1,   7'd1,    80);
        run_phase(7'd127, 7'd127, 7'd127, 200);
        run_phase(7'd4,   7'd4,   7'd4,   100);
        run_phase(7'd64,  7'd1,   7'd64,  100);
        run_phase(7'd1,   7'd64,  7'd1,   150);
        run_phase(7'd0,   7'd5,   7'd7,    40);
        run_phase(7'd5,   7'd0,   7'd5,    40);
        run_phase(7'd8,   7'd3,   7'd6,   100);
        run_phase(7'd2,   7'd16,  7'd3,   100);
        run_phase(7'd3,   7'd7,   7'd0,    30);
        run_phase(7'd64,  7'd64,  7'd64,  130);
        run_phase(7'd6,   7'd2,   7'd9,    80);

        settle();
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
